@@ design/jet_pkg.sv @@
// Shared types, constants and helpers for the Julia escape-time pixel unit.
`default_nettype none

package jet_pkg;

   // Field widths
   localparam int COORD_WIDTH = 32;
   localparam int PROD_WIDTH  = 64;
   localparam int INDEX_WIDTH = 10;
   localparam int COUNT_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 3;

   // Default fraction width (Q5.26)
   localparam int FRACTION_BITS_DEFAULT = 26;

   // Register reset values
   localparam logic signed [COORD_WIDTH-1:0] ORIGIN_RESET = -32'sd134217728;
   localparam logic signed [COORD_WIDTH-1:0] STEP_RESET   = 32'sd262144;
   localparam logic signed [COORD_WIDTH-1:0] CONST_RESET  = 32'sd0;
   localparam logic [COUNT_WIDTH-1:0]        LIMIT_RESET  = 16'd256;

   // Saturation bounds of a coordinate
   localparam logic signed [PROD_WIDTH-1:0] COORD_MAX = 64'sd2147483647;
   localparam logic signed [PROD_WIDTH-1:0] COORD_MIN = -64'sd2147483648;

   // Register map
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_ORIGIN_REAL     = 3'd0,
      CSR_ORIGIN_IMAG     = 3'd1,
      CSR_STEP_REAL       = 3'd2,
      CSR_STEP_IMAG       = 3'd3,
      CSR_CONST_REAL      = 3'd4,
      CSR_CONST_IMAG      = 3'd5,
      CSR_ITERATION_LIMIT = 3'd6
   } csr_index_type;

   // Register file contents
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] origin_real;
      logic signed [COORD_WIDTH-1:0] origin_imag;
      logic signed [COORD_WIDTH-1:0] step_real;
      logic signed [COORD_WIDTH-1:0] step_imag;
      logic signed [COORD_WIDTH-1:0] const_real;
      logic signed [COORD_WIDTH-1:0] const_imag;
      logic [COUNT_WIDTH-1:0]        iteration_limit;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // capture pixel indices
      logic init;    // form start point, clear count
      logic mul;     // register the three products of z
      logic update;  // form next z from products, bump count
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic finished;  // escaped after an iteration, or limit reached
   } dp_status_type;

   // Clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [COORD_WIDTH-1:0] sat32(
      input logic signed [PROD_WIDTH-1:0] value
   );
      logic signed [COORD_WIDTH-1:0] result;
      if (value > COORD_MAX) begin
         result = COORD_MAX[COORD_WIDTH-1:0];
      end else if (value < COORD_MIN) begin
         result = COORD_MIN[COORD_WIDTH-1:0];
      end else begin
         result = value[COORD_WIDTH-1:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

@@ design/julia_escape_time.sv @@
// Julia-set escape-time pixel unit: top level.
// Each pixel forms its start point and then runs its iterations (none when the limit is
// zero); each iteration has a multiply step for the three registered 32x32 products
// and an update step for the update of z and escape test.
// A new start beat is taken only once the block is idle again, the cycle after
// the strobe. Synchronous reset idles the block and loads the register defaults.
`default_nettype none

module julia_escape_time #(
   parameter int FRACTION_BITS = jet_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [jet_pkg::INDEX_WIDTH-1:0]      req_column_index,
   input  wire logic [jet_pkg::INDEX_WIDTH-1:0]      req_row_index,
   output logic                                      rsp_strobe,
   output logic [jet_pkg::COUNT_WIDTH-1:0]           rsp_iteration_count,
   output logic [jet_pkg::INDEX_WIDTH-1:0]           rsp_column_out,
   output logic [jet_pkg::INDEX_WIDTH-1:0]           rsp_row_out,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [jet_pkg::CSR_ADDR_WIDTH-1:0]   csr_index,
   input  wire logic [jet_pkg::COORD_WIDTH-1:0]      csr_wdata
);

   jet_pkg::cfg_type       cfg;
   jet_pkg::dp_cmd_type    cmd;
   jet_pkg::dp_status_type status;

   // Register file
   jet_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer
   jet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   // Arithmetic
   jet_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .cfg              (cfg),
      .req_column_index (req_column_index),
      .req_row_index    (req_row_index),
      .iteration_count  (rsp_iteration_count),
      .column_out       (rsp_column_out),
      .row_out          (rsp_row_out)
   );

   // Checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted start beat did not raise busy");

   a_busy_until_result: assert property (@(posedge clock) disable iff (reset)
      (busy && !rsp_strobe) |=> busy)
      else $error("busy dropped before the result beat");

   a_count_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_iteration_count <= cfg.iteration_limit))
      else $error("iteration count beyond the configured limit");

endmodule

`default_nettype wire

@@ design/jet_csr.sv @@
// Configuration register file for the Julia escape-time pixel unit.
`default_nettype none

module jet_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [jet_pkg::CSR_ADDR_WIDTH-1:0]   csr_index,
   input  wire logic [jet_pkg::COORD_WIDTH-1:0]      csr_wdata,
   output jet_pkg::cfg_type                          cfg
);

   jet_pkg::cfg_type cfg_ff;
   jet_pkg::cfg_type cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode one write beat
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (jet_pkg::csr_index_type'(csr_index))
            jet_pkg::CSR_ORIGIN_REAL:     cfg_in.origin_real = $signed(csr_wdata);
            jet_pkg::CSR_ORIGIN_IMAG:     cfg_in.origin_imag = $signed(csr_wdata);
            jet_pkg::CSR_STEP_REAL:       cfg_in.step_real   = $signed(csr_wdata);
            jet_pkg::CSR_STEP_IMAG:       cfg_in.step_imag   = $signed(csr_wdata);
            jet_pkg::CSR_CONST_REAL:      cfg_in.const_real  = $signed(csr_wdata);
            jet_pkg::CSR_CONST_IMAG:      cfg_in.const_imag  = $signed(csr_wdata);
            jet_pkg::CSR_ITERATION_LIMIT: begin
               cfg_in.iteration_limit = csr_wdata[jet_pkg::COUNT_WIDTH-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_real     <= jet_pkg::ORIGIN_RESET;
         cfg_ff.origin_imag     <= jet_pkg::ORIGIN_RESET;
         cfg_ff.step_real       <= jet_pkg::STEP_RESET;
         cfg_ff.step_imag       <= jet_pkg::STEP_RESET;
         cfg_ff.const_real      <= jet_pkg::CONST_RESET;
         cfg_ff.const_imag      <= jet_pkg::CONST_RESET;
         cfg_ff.iteration_limit <= jet_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ design/jet_datapath.sv @@
// Datapath: start point, complex square with products registered, count.
`default_nettype none

module jet_datapath #(
   parameter int FRACTION_BITS = jet_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire jet_pkg::dp_cmd_type                  cmd,
   output jet_pkg::dp_status_type                    status,
   input  wire jet_pkg::cfg_type                     cfg,
   input  wire logic [jet_pkg::INDEX_WIDTH-1:0]      req_column_index,
   input  wire logic [jet_pkg::INDEX_WIDTH-1:0]      req_row_index,
   output logic [jet_pkg::COUNT_WIDTH-1:0]           iteration_count,
   output logic [jet_pkg::INDEX_WIDTH-1:0]           column_out,
   output logic [jet_pkg::INDEX_WIDTH-1:0]           row_out
);

   localparam int CW = jet_pkg::COORD_WIDTH;
   localparam int PW = jet_pkg::PROD_WIDTH;
   localparam int IW = jet_pkg::INDEX_WIDTH;
   localparam int NW = jet_pkg::COUNT_WIDTH;

   // |z|^2 escape bound: 4.0 squared-scale
   localparam logic [PW-1:0] ESCAPE_BOUND = PW'(4) << (2 * FRACTION_BITS);

   logic [IW-1:0]        col_ff, col_in;
   logic [IW-1:0]        row_ff, row_in;
   logic signed [CW-1:0] zr_ff, zr_in;
   logic signed [CW-1:0] zi_ff, zi_in;
   logic signed [PW-1:0] prr_ff, prr_in;
   logic signed [PW-1:0] pii_ff, pii_in;
   logic signed [PW-1:0] pri_ff, pri_in;
   logic [NW-1:0]        count_ff, count_in;

   logic signed [PW-1:0] start_re;
   logic signed [PW-1:0] start_im;
   logic signed [PW-1:0] diff;
   logic signed [PW-1:0] next_re;
   logic signed [PW-1:0] next_im;
   logic [PW-1:0]        mag_sum;
   logic                 escaped;

   // Start point: origin + index * step
   always_comb begin
      start_re = PW'($signed({1'b0, col_ff})) * PW'(cfg.step_real) + PW'(cfg.origin_real);
      start_im = PW'($signed({1'b0, row_ff})) * PW'(cfg.step_imag) + PW'(cfg.origin_imag);
   end

   // Next z from the registered products
   always_comb begin
      diff    = prr_ff - pii_ff;
      next_re = (diff >>> FRACTION_BITS) + PW'(cfg.const_real);
      next_im = (pri_ff >>> (FRACTION_BITS - 1)) + PW'(cfg.const_imag);
   end

   // Escape test on squares of the current z (both squares are non-negative)
   always_comb begin
      mag_sum = $unsigned(prr_ff) + $unsigned(pii_ff);
      escaped = (mag_sum >= ESCAPE_BOUND);
      status.finished = (count_ff == cfg.iteration_limit) ||
                        ((count_ff != '0) && escaped);
   end

   // Next-state values
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      count_in = count_ff;
      prr_in   = prr_ff;
      pii_in   = pii_ff;
      pri_in   = pri_ff;
      if (cmd.load) begin
         col_in = req_column_index;
         row_in = req_row_index;
      end
      if (cmd.init) begin
         zr_in    = jet_pkg::sat32(start_re);
         zi_in    = jet_pkg::sat32(start_im);
         count_in = '0;
      end else if (cmd.update) begin
         zr_in    = jet_pkg::sat32(next_re);
         zi_in    = jet_pkg::sat32(next_im);
         count_in = count_ff + NW'(1);
      end
      if (cmd.mul) begin
         prr_in = PW'(zr_ff) * PW'(zr_ff);
         pii_in = PW'(zi_ff) * PW'(zi_ff);
         pri_in = PW'(zr_ff) * PW'(zi_ff);
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      row_ff   <= row_in;
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      count_ff <= count_in;
      prr_ff   <= prr_in;
      pii_ff   <= pii_in;
      pri_ff   <= pri_in;
   end

   assign iteration_count = count_ff;
   assign column_out      = col_ff;
   assign row_out         = row_ff;

endmodule

`default_nettype wire

@@ design/jet_ctrl.sv @@
// Controller: sequences start point, multiply and update steps per pixel.
`default_nettype none

module jet_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_strobe,
   output jet_pkg::dp_cmd_type         cmd,
   input  wire jet_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_MUL,
      ST_EVAL,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   // Commands to the datapath
   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == ST_IDLE) && start;
      cmd.init   = (state_ff == ST_INIT);
      cmd.mul    = (state_ff == ST_MUL);
      cmd.update = (state_ff == ST_EVAL) && !status.finished;
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_INIT;
                  busy_ff  <= 1'b1;
               end
            end
            ST_INIT: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (status.finished) begin
                  state_ff  <= ST_DONE;
                  strobe_ff <= 1'b1;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_DONE: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b0;
            end
            default: begin
               state_ff  <= ST_IDLE;
               busy_ff   <= 1'b0;
               strobe_ff <= 1'b0;
            end
         endcase
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire
